// ----- src/life_generation_rows_macros.svh -----
// assertion helpers shared by the block
`ifndef LIFE_GENERATION_ROWS_MACROS_SVH
`define LIFE_GENERATION_ROWS_MACROS_SVH

// check that cons holds in the same cycle as ante
`define LGR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check that cons holds in the cycle after ante
`define LGR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/lgr_pkg.sv -----
`timescale 1ns / 1ps

package lgr_pkg;

    // fixed field widths
    localparam int CELLS_W      = 64;
    localparam int ROW_W        = 6;
    localparam int GRID_W       = 7;

    // grid limits and rule
    localparam int MAX_GRID_DEF = 64;
    localparam int GRID_MIN     = 3;
    localparam int BIRTH_COUNT  = 3;

    // result queue depth, a power of two
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // one result row
    typedef struct packed {
        logic [CELLS_W-1:0] cells;
        logic [ROW_W-1:0]   row_number;
        logic               row_changed;
        logic               frame_changed;
        logic               last;
    } t_result;

    // queue status seen by the top level
    typedef struct packed {
        logic room_for_two;
        logic not_empty;
    } t_queue_status;

endpackage

// ----- src/life_generation_rows.sv -----
`timescale 1ns / 1ps
// one generation of life (b3/s23) on a square grid, streamed by rows
// slave side: one request per grid row, tdata bit k is column k, rows in
// order from row 0; bits at or beyond the grid size are ignored
// master side: one request per new row, tdata holds the cells and the row
// number, tuser holds the row and frame change flags, tlast marks the
// final row of the grid
// config: i_cfg_wr_en writes the grid size, clamped to 3..MAX_GRID; write
// it only between frames or while the block is idle
// order: the result for row r is queued when row r+1 is taken; the final
// row queues two results at once, the row before it and then its own
// throughput: one row per cycle while input ready is high, all cells of
// a row computed combinationally in parallel; a four-entry result queue
// sets the stall behavior: input ready drops while it holds more than two
// results, so a stalled receiver backs up the input within four rows
// reset: grid size goes to MAX_GRID, the frame restarts at row 0 and the
// result queue empties
module life_generation_rows #(
    parameter int MAX_GRID = lgr_pkg::MAX_GRID_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // config
    input  logic                        i_cfg_wr_en,
    input  logic [lgr_pkg::GRID_W-1:0]  i_cfg_wr_data,
    // input rows
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [63:0]                 i_s_axis_tdata,  // [63:0] row_cells
    // result rows
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [71:0]                 o_m_axis_tdata,  // [63:0] new_row_cells,
                                                         // [69:64] row_number, [71:70] 0
    output logic [1:0]                  o_m_axis_tuser,  // [0] row_changed,
                                                         // [1] frame_changed
    output logic                        o_m_axis_tlast
);

    logic [lgr_pkg::GRID_W-1:0]  r_grid;
    logic [lgr_pkg::CELLS_W-1:0] r_older;
    logic [lgr_pkg::CELLS_W-1:0] r_middle;
    logic [lgr_pkg::ROW_W-1:0]   r_rows;
    logic                        r_any;

    logic [lgr_pkg::GRID_W-1:0]  n_grid;
    logic [lgr_pkg::CELLS_W-1:0] w_gm;
    logic [lgr_pkg::CELLS_W-1:0] w_cur;
    logic [lgr_pkg::CELLS_W-1:0] w_row_cells;
    logic                        w_row_changed;
    logic                        w_in_acc;
    logic                        w_out_acc;
    logic                        w_first;
    logic                        w_second;
    logic                        w_final;
    logic                        w_push0;
    logic                        w_push1;
    lgr_pkg::t_result            w_res0;
    lgr_pkg::t_result            w_res1;
    lgr_pkg::t_result            w_head;
    lgr_pkg::t_queue_status      w_qs;

    // grid size write with clamp
    always_comb begin
        n_grid = r_grid;
        if (i_cfg_wr_en) begin
            if (i_cfg_wr_data < lgr_pkg::GRID_W'(lgr_pkg::GRID_MIN)) begin
                n_grid = lgr_pkg::GRID_W'(lgr_pkg::GRID_MIN);
            end else if (i_cfg_wr_data > lgr_pkg::GRID_W'(MAX_GRID)) begin
                n_grid = lgr_pkg::GRID_W'(MAX_GRID);
            end else begin
                n_grid = i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid <= lgr_pkg::GRID_W'(MAX_GRID);
        end else begin
            r_grid <= n_grid;
        end
    end

    // column mask of the current grid
    always_comb begin
        for (int k = 0; k < lgr_pkg::CELLS_W; k++) begin
            w_gm[k] = lgr_pkg::GRID_W'(k) < r_grid;
        end
    end

    assign w_in_acc  = i_s_axis_tvalid & o_s_axis_tready;
    assign w_out_acc = o_m_axis_tvalid & i_m_axis_tready;
    assign w_cur     = i_s_axis_tdata & w_gm;
    assign w_first   = r_rows == '0;
    assign w_second  = r_rows == lgr_pkg::ROW_W'(1);
    assign w_final   = ({1'b0, r_rows} + lgr_pkg::GRID_W'(1)) >= r_grid;

    // parallel cell lanes over the three-row window
    lgr_row #(
        .MAX_GRID (MAX_GRID)
    ) u_row (
        .i_up      (r_older),
        .i_mid     (r_middle),
        .i_down    (w_cur),
        .i_grid    (r_grid),
        .o_cells   (w_row_cells),
        .o_changed (w_row_changed)
    );

    // results caused by this row
    always_comb begin
        w_res0 = '0;
        if (w_second) begin
            w_res0.cells = r_middle & w_gm;
        end else begin
            w_res0.cells       = w_row_cells;
            w_res0.row_number  = r_rows - lgr_pkg::ROW_W'(1);
            w_res0.row_changed = w_row_changed;
        end
        w_res1               = '0;
        w_res1.cells         = w_cur;
        w_res1.row_number    = r_rows;
        w_res1.frame_changed = r_any | (w_row_changed & ~w_second);
        w_res1.last          = 1'b1;
    end

    assign w_push0 = w_in_acc & ~w_first;
    assign w_push1 = w_in_acc & w_final;

    // row window and frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_older  <= '0;
            r_middle <= '0;
            r_rows   <= '0;
            r_any    <= 1'b0;
        end else if (w_in_acc) begin
            if (w_first) begin
                r_middle <= w_cur;
                r_rows   <= lgr_pkg::ROW_W'(1);
            end else if (w_final) begin
                r_older  <= '0;
                r_middle <= '0;
                r_rows   <= '0;
                r_any    <= 1'b0;
            end else begin
                r_older  <= r_middle;
                r_middle <= w_cur;
                r_rows   <= r_rows + lgr_pkg::ROW_W'(1);
                r_any    <= r_any | (w_row_changed & ~w_second);
            end
        end
    end

    // result queue decouples the two sides
    lgr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push0  (w_push0),
        .i_data0  (w_res0),
        .i_push1  (w_push1),
        .i_data1  (w_res1),
        .i_pop    (w_out_acc),
        .o_head   (w_head),
        .o_status (w_qs)
    );

    assign o_s_axis_tready = w_qs.room_for_two;
    assign o_m_axis_tvalid = w_qs.not_empty;
    assign o_m_axis_tdata  = {2'b00, w_head.row_number, w_head.cells};
    assign o_m_axis_tuser  = {w_head.frame_changed, w_head.row_changed};
    assign o_m_axis_tlast  = w_head.last;

    // checks
`include "life_generation_rows_macros.svh"

    `LGR_ASSERT_NEXT(a_final_shows, i_clk, i_rst_n, w_in_acc && w_final, o_m_axis_tvalid, "final row gave no result")
    `LGR_ASSERT_NEXT(a_first_stored, i_clk, i_rst_n, w_in_acc && w_first, r_rows == lgr_pkg::ROW_W'(1), "first row not stored")
    `LGR_ASSERT_SAME(a_border_quiet, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tlast, !o_m_axis_tuser[0], "final border row flagged changed")
    `LGR_ASSERT_SAME(a_frame_on_last, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tlast, !o_m_axis_tuser[1], "frame flag before last row")

endmodule

// ----- src/lgr_lane.sv -----
`timescale 1ns / 1ps

module lgr_lane (
    input  logic [2:0] i_up,
    input  logic [2:0] i_mid,
    input  logic [2:0] i_down,
    output logic       o_cell
);

    logic [3:0] w_count;

    // live cells in the 3x3 block, center included
    assign w_count = 4'(i_up[0]) + 4'(i_up[1]) + 4'(i_up[2])
                   + 4'(i_mid[0]) + 4'(i_mid[1]) + 4'(i_mid[2])
                   + 4'(i_down[0]) + 4'(i_down[1]) + 4'(i_down[2]);

    // b3/s23 with the center counted
    assign o_cell = (w_count == 4'(lgr_pkg::BIRTH_COUNT))
                 || ((w_count == 4'(lgr_pkg::BIRTH_COUNT + 1)) && i_mid[1]);

endmodule

// ----- src/lgr_row.sv -----
`timescale 1ns / 1ps

module lgr_row #(
    parameter int MAX_GRID = lgr_pkg::MAX_GRID_DEF
) (
    input  logic [lgr_pkg::CELLS_W-1:0] i_up,
    input  logic [lgr_pkg::CELLS_W-1:0] i_mid,
    input  logic [lgr_pkg::CELLS_W-1:0] i_down,
    input  logic [lgr_pkg::GRID_W-1:0]  i_grid,
    output logic [lgr_pkg::CELLS_W-1:0] o_cells,
    output logic                        o_changed
);

    logic [lgr_pkg::CELLS_W-1:0] w_diff;

    for (genvar k = 0; k < lgr_pkg::CELLS_W; k++) begin : g_col
        logic w_in_grid;
        logic w_interior;
        logic w_rule;

        assign w_in_grid  = lgr_pkg::GRID_W'(k) < i_grid;
        assign w_interior = lgr_pkg::GRID_W'(k + 1) < i_grid;

        if (k >= 1 && k <= MAX_GRID - 2) begin : g_lane
            // interior column candidate: one rule lane
            lgr_lane u_lane (
                .i_up   (i_up[k+1:k-1]),
                .i_mid  (i_mid[k+1:k-1]),
                .i_down (i_down[k+1:k-1]),
                .o_cell (w_rule)
            );
            assign o_cells[k] = w_interior ? w_rule : (w_in_grid & i_mid[k]);
        end else begin : g_edge
            // border or unused column passes the masked cell
            assign w_rule     = 1'b0;
            assign o_cells[k] = w_in_grid & i_mid[k] & ~w_rule;
        end

        assign w_diff[k] = o_cells[k] ^ (w_in_grid & i_mid[k]);
    end

    // merge lane results into the row change flag
    assign o_changed = |w_diff;

endmodule

// ----- src/lgr_queue.sv -----
`timescale 1ns / 1ps

module lgr_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push0,
    input  lgr_pkg::t_result       i_data0,
    input  logic                   i_push1,
    input  lgr_pkg::t_result       i_data1,
    input  logic                   i_pop,
    output lgr_pkg::t_result       o_head,
    output lgr_pkg::t_queue_status o_status
);

    lgr_pkg::t_result                r_mem [lgr_pkg::QUEUE_DEPTH];
    logic [lgr_pkg::QPTR_W-1:0]      r_wr;
    logic [lgr_pkg::QPTR_W-1:0]      r_rd;
    logic [lgr_pkg::QCNT_W-1:0]      r_count;
    logic [lgr_pkg::QPTR_W-1:0]      w_wr1;
    logic [lgr_pkg::QPTR_W-1:0]      n_wr;
    logic [lgr_pkg::QPTR_W-1:0]      n_rd;
    logic [lgr_pkg::QCNT_W-1:0]      n_count;

    // second write lands after the first
    assign w_wr1 = r_wr + lgr_pkg::QPTR_W'(i_push0);

    always_comb begin
        n_wr    = r_wr + lgr_pkg::QPTR_W'(i_push0) + lgr_pkg::QPTR_W'(i_push1);
        n_rd    = r_rd + lgr_pkg::QPTR_W'(i_pop);
        n_count = r_count + lgr_pkg::QCNT_W'(i_push0) + lgr_pkg::QCNT_W'(i_push1)
                - lgr_pkg::QCNT_W'(i_pop);
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_mem[r_wr] <= i_data0;
        end
        if (i_push1) begin
            r_mem[w_wr1] <= i_data1;
        end
    end

    assign o_head                = r_mem[r_rd];
    assign o_status.not_empty    = r_count != '0;
    assign o_status.room_for_two = r_count <= lgr_pkg::QCNT_W'(lgr_pkg::QUEUE_DEPTH - 2);

endmodule
